// ----- src/eink_repaint_scheduler_core_macros.svh -----
// assertion macros shared by the e-ink repaint scheduler rtl
// no dependencies; included by files that carry concurrent checks
`ifndef EINK_REPAINT_SCHEDULER_CORE_MACROS_SVH
`define EINK_REPAINT_SCHEDULER_CORE_MACROS_SVH

// property checked on every rising edge outside reset
`define ERS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// implication checked on every rising edge outside reset
`define ERS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define ERS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ers_pkg.sv -----
// shared types and constants of the e-ink repaint scheduler
// no dependencies; imported by every module of the block
`default_nettype none

package ers_pkg;

    localparam int FIELD_W            = 12;
    localparam int COORD_BITS_DEFAULT = 12;
    localparam int LIMIT_W            = 4;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;
    localparam logic [LIMIT_W-1:0] COUNT_MAX   = 4'hF;
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        REQ_FULL    = 2'd0,
        REQ_PARTIAL = 2'd1,
        REQ_DONE    = 2'd2,
        REQ_EXIT    = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        START_NONE    = 2'd0,
        START_FULL    = 2'd1,
        START_PARTIAL = 2'd2
    } start_t;

    typedef struct packed {
        req_type_t          req_type;
        logic [FIELD_W-1:0] rect_left;
        logic [FIELD_W-1:0] rect_top;
        logic [FIELD_W-1:0] rect_right;
        logic [FIELD_W-1:0] rect_bottom;
    } item_t;

    typedef struct packed {
        logic               finish_full;
        logic               finish_partial;
        start_t             start_action;
        logic [FIELD_W-1:0] out_left;
        logic [FIELD_W-1:0] out_top;
        logic [FIELD_W-1:0] out_right;
        logic [FIELD_W-1:0] out_bottom;
        logic               exit_now;
    } result_t;

endpackage

`default_nettype wire

// ----- src/ers_in_stage.sv -----
// input register of the e-ink repaint scheduler: unpacks and holds one request
// depends on ers_pkg
`default_nettype none

module ers_in_stage
    import ers_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // rect_left, rect_top, rect_right, rect_bottom
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // req_type
    input  wire logic                 advance,
    output logic                      item_valid,
    output item_t                     item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;

    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_tready) begin
            valid_next            = s_tvalid;
            item_next.req_type    = req_type_t'(s_tuser);
            item_next.rect_left   = s_tdata[FIELD_W-1:0];
            item_next.rect_top    = s_tdata[2*FIELD_W-1:FIELD_W];
            item_next.rect_right  = s_tdata[3*FIELD_W-1:2*FIELD_W];
            item_next.rect_bottom = s_tdata[4*FIELD_W-1:3*FIELD_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- src/ers_sched.sv -----
// refresh scheduling state and per-request decision logic
// depends on ers_pkg and eink_repaint_scheduler_core_macros.svh
`default_nettype none
`include "eink_repaint_scheduler_core_macros.svh"

module ers_sched
    import ers_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [LIMIT_W-1:0] cfg_wr_data,
    input  wire logic               fire,
    input  wire item_t              item,
    output result_t                 result
);

    localparam int CW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;

    logic [LIMIT_W-1:0] limit_reg;
    logic               full_running_reg,    full_running_next;
    logic               partial_running_reg, partial_running_next;
    logic               full_queued_reg,     full_queued_next;
    logic               partial_queued_reg,  partial_queued_next;
    logic [LIMIT_W-1:0] count_reg,           count_next;
    logic               exit_pending_reg,    exit_pending_next;
    logic               exited_reg,          exited_next;
    logic [CW-1:0]      qrect_reg [4];
    logic [CW-1:0]      qrect_next [4];
    logic [CW-1:0]      rect [4];
    logic               idle;
    result_t            res;

    assign rect[0] = item.rect_left[CW-1:0];
    assign rect[1] = item.rect_top[CW-1:0];
    assign rect[2] = item.rect_right[CW-1:0];
    assign rect[3] = item.rect_bottom[CW-1:0];
    assign idle    = !(full_running_reg || partial_running_reg);

    always_comb begin
        logic take_full;
        full_running_next    = full_running_reg;
        partial_running_next = partial_running_reg;
        full_queued_next     = full_queued_reg;
        partial_queued_next  = partial_queued_reg;
        count_next           = count_reg;
        exit_pending_next    = exit_pending_reg;
        exited_next          = exited_reg;
        qrect_next           = qrect_reg;
        res                  = '0;
        take_full            = 1'b0;
        if (!exited_reg) begin
            case (item.req_type)
                REQ_FULL: begin
                    take_full = 1'b1;
                end
                REQ_PARTIAL: begin
                    if (count_reg >= limit_reg) begin
                        count_next = '0;
                        take_full  = 1'b1;
                    end else if (idle) begin
                        count_next           = count_reg + 1'b1;
                        partial_running_next = 1'b1;
                        res.start_action     = START_PARTIAL;
                        res.out_left         = FIELD_W'(rect[0]);
                        res.out_top          = FIELD_W'(rect[1]);
                        res.out_right        = FIELD_W'(rect[2]);
                        res.out_bottom       = FIELD_W'(rect[3]);
                    end else if (full_queued_reg) begin
                        // dropped, a full refresh covers it
                    end else if (partial_queued_reg) begin
                        for (int i = 0; i < 2; i++) begin
                            if (rect[i] < qrect_reg[i]) begin
                                qrect_next[i] = rect[i];
                            end
                        end
                        for (int i = 2; i < 4; i++) begin
                            if (rect[i] > qrect_reg[i]) begin
                                qrect_next[i] = rect[i];
                            end
                        end
                    end else begin
                        qrect_next          = rect;
                        partial_queued_next = 1'b1;
                    end
                end
                REQ_DONE: begin
                    if (full_running_reg) begin
                        full_running_next = 1'b0;
                        count_next        = '0;
                        res.finish_full   = 1'b1;
                    end
                    if (partial_running_reg) begin
                        partial_running_next = 1'b0;
                        res.finish_partial   = 1'b1;
                    end
                    if (exit_pending_reg) begin
                        exited_next  = 1'b1;
                        res.exit_now = 1'b1;
                    end else if (full_queued_reg) begin
                        full_queued_next  = 1'b0;
                        full_running_next = 1'b1;
                        res.start_action  = START_FULL;
                    end else if (partial_queued_reg) begin
                        partial_queued_next  = 1'b0;
                        partial_running_next = 1'b1;
                        if (count_next != COUNT_MAX) begin
                            count_next = count_next + 1'b1;
                        end
                        res.start_action = START_PARTIAL;
                        res.out_left     = FIELD_W'(qrect_reg[0]);
                        res.out_top      = FIELD_W'(qrect_reg[1]);
                        res.out_right    = FIELD_W'(qrect_reg[2]);
                        res.out_bottom   = FIELD_W'(qrect_reg[3]);
                    end
                end
                REQ_EXIT: begin
                    if (idle) begin
                        exited_next  = 1'b1;
                        res.exit_now = 1'b1;
                    end else begin
                        exit_pending_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (take_full) begin
                if (idle) begin
                    full_running_next = 1'b1;
                    res.start_action  = START_FULL;
                end else begin
                    full_queued_next    = 1'b1;
                    partial_queued_next = 1'b0;
                end
            end
        end
    end

    assign result = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg           <= LIMIT_RESET;
            full_running_reg    <= 1'b0;
            partial_running_reg <= 1'b0;
            full_queued_reg     <= 1'b0;
            partial_queued_reg  <= 1'b0;
            count_reg           <= '0;
            exit_pending_reg    <= 1'b0;
            exited_reg          <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (fire) begin
                full_running_reg    <= full_running_next;
                partial_running_reg <= partial_running_next;
                full_queued_reg     <= full_queued_next;
                partial_queued_reg  <= partial_queued_next;
                count_reg           <= count_next;
                exit_pending_reg    <= exit_pending_next;
                exited_reg          <= exited_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            qrect_reg <= qrect_next;
        end
    end

    `ERS_ASSERT(a_one_running, aclk, aresetn, !(full_running_reg && partial_running_reg), "full and partial refresh running together")
    `ERS_ASSERT(a_one_queued, aclk, aresetn, !(full_queued_reg && partial_queued_reg), "full and partial refresh queued together")
    `ERS_ASSERT_IMPL(a_queue_busy, aclk, aresetn, full_queued_reg || partial_queued_reg, full_running_reg || partial_running_reg || exited_reg, "refresh queued while panel idle")
    `ERS_ASSERT_NEXT(a_exit_sticky, aclk, aresetn, exited_reg, exited_reg, "exited state cleared")
    `ERS_ASSERT_NEXT(a_partial_starts, aclk, aresetn, fire && res.start_action == START_PARTIAL, partial_running_reg && !full_running_reg, "partial start not tracked")

endmodule

`default_nettype wire

// ----- src/ers_out_stage.sv -----
// result register of the e-ink repaint scheduler: packs and holds one result
// depends on ers_pkg
`default_nettype none

module ers_out_stage
    import ers_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire result_t              result,
    output logic                      can_load,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // finish_full, finish_partial, out_left,
                                                 // out_top, out_right, out_bottom, exit_now
    output logic [M_TUSER_W-1:0]      m_tuser    // start_action
);

    localparam int PAD_W = M_TDATA_W - 4 * FIELD_W - 3;

    logic                 valid_reg;
    logic [M_TDATA_W-1:0] data_reg;
    logic [M_TUSER_W-1:0] user_reg;

    assign can_load = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load && load) begin
            data_reg <= {{PAD_W{1'b0}}, result.exit_now, result.out_bottom, result.out_right,
                         result.out_top, result.out_left, result.finish_partial,
                         result.finish_full};
            user_reg <= result.start_action;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

`default_nettype wire

// ----- src/eink_repaint_scheduler_core.sv -----
// top level of the e-ink repaint scheduler
// depends on ers_pkg, ers_in_stage, ers_sched and ers_out_stage
`default_nettype none

// Takes one request per clock (full refresh, partial rectangle, busy done edge,
// exit) and returns exactly one result per request. Each request passes an
// input register, combinational decision logic against the scheduler state and
// a result register; the sustained rate is one item per clock, and s_tready
// drops only while the result register is full and m_tready is low.
// partial_limit is written through cfg_wr_en/cfg_wr_data and resets to 5;
// write it only while no item is in flight.
module eink_repaint_scheduler_core
    import ers_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [LIMIT_W-1:0]   cfg_wr_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // rect_left, rect_top, rect_right, rect_bottom
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // req_type
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // finish_full, finish_partial, out_left,
                                                 // out_top, out_right, out_bottom, exit_now
    output logic [M_TUSER_W-1:0]      m_tuser    // start_action
);

    logic    advance;
    logic    item_valid;
    logic    fire;
    item_t   item;
    result_t result;

    assign fire = item_valid && advance;

    ers_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ers_sched #(
        .COORD_BITS (COORD_BITS)
    ) u_sched (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .item        (item),
        .result      (result)
    );

    ers_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (item_valid),
        .result   (result),
        .can_load (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// self-checking testbench for eink_repaint_scheduler_core: random and directed refresh
// requests on the input stream, every result checked against a cycle-free schedule model
// depends on ers_pkg and eink_repaint_scheduler_core; needs nothing else
`default_nettype none

import ers_pkg::*;

class refresh_plan;
    logic [LIMIT_W-1:0] partial_limit;
    logic [LIMIT_W-1:0] partial_count;
    bit                 full_running;
    bit                 partial_running;
    bit                 full_queued;
    bit                 partial_queued;
    bit                 exit_pending;
    bit                 exited;
    logic [FIELD_W-1:0] pend_left;
    logic [FIELD_W-1:0] pend_top;
    logic [FIELD_W-1:0] pend_right;
    logic [FIELD_W-1:0] pend_bottom;
    result_t            due_results[$];
    int                 errors;
    int                 requests;
    int                 results;
    int                 full_starts;
    int                 partial_starts;
    int                 forced_fulls;
    int                 merges;
    int                 shutdowns;

    function new();
        partial_limit   = LIMIT_RESET;
        partial_count   = '0;
        full_running    = 1'b0;
        partial_running = 1'b0;
        full_queued     = 1'b0;
        partial_queued  = 1'b0;
        exit_pending    = 1'b0;
        exited          = 1'b0;
        pend_left       = '0;
        pend_top        = '0;
        pend_right      = '0;
        pend_bottom     = '0;
        errors          = 0;
        requests        = 0;
        results         = 0;
        full_starts     = 0;
        partial_starts  = 0;
        forced_fulls    = 0;
        merges          = 0;
        shutdowns       = 0;
    endfunction

    function void set_limit(input logic [LIMIT_W-1:0] value);
        partial_limit = value;
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    function bit panel_busy();
        return full_running || partial_running;
    endfunction

    function void start_partial(input logic [FIELD_W-1:0] l, input logic [FIELD_W-1:0] t,
                                input logic [FIELD_W-1:0] r, input logic [FIELD_W-1:0] b,
                                inout result_t res);
        if (partial_count != COUNT_MAX) begin
            partial_count = partial_count + 1'b1;
        end
        partial_running  = 1'b1;
        res.start_action = START_PARTIAL;
        res.out_left     = l;
        res.out_top      = t;
        res.out_right    = r;
        res.out_bottom   = b;
        partial_starts++;
    endfunction

    function void request_full(inout result_t res);
        if (!panel_busy()) begin
            full_running     = 1'b1;
            res.start_action = START_FULL;
            full_starts++;
        end else begin
            full_queued    = 1'b1;
            partial_queued = 1'b0;
        end
    endfunction

    function void request_partial(input item_t it, inout result_t res);
        if (partial_count >= partial_limit) begin
            // too many partials in a row, promote to full
            partial_count = '0;
            forced_fulls++;
            request_full(res);
        end else if (!panel_busy()) begin
            start_partial(it.rect_left, it.rect_top, it.rect_right, it.rect_bottom, res);
        end else if (!full_queued) begin
            if (partial_queued) begin
                if (it.rect_left < pend_left) pend_left = it.rect_left;
                if (it.rect_top < pend_top) pend_top = it.rect_top;
                if (it.rect_right > pend_right) pend_right = it.rect_right;
                if (it.rect_bottom > pend_bottom) pend_bottom = it.rect_bottom;
                merges++;
            end else begin
                pend_left      = it.rect_left;
                pend_top       = it.rect_top;
                pend_right     = it.rect_right;
                pend_bottom    = it.rect_bottom;
                partial_queued = 1'b1;
            end
        end
    endfunction

    function void busy_done(inout result_t res);
        if (full_running) begin
            full_running    = 1'b0;
            partial_count   = '0;
            res.finish_full = 1'b1;
        end
        if (partial_running) begin
            partial_running    = 1'b0;
            res.finish_partial = 1'b1;
        end
        if (exit_pending) begin
            exited       = 1'b1;
            res.exit_now = 1'b1;
            shutdowns++;
        end else if (full_queued) begin
            full_queued      = 1'b0;
            full_running     = 1'b1;
            res.start_action = START_FULL;
            full_starts++;
        end else if (partial_queued) begin
            partial_queued = 1'b0;
            start_partial(pend_left, pend_top, pend_right, pend_bottom, res);
        end
    endfunction

    function void note_request(input item_t it);
        result_t res;
        res = '0;
        requests++;
        if (!exited) begin
            case (it.req_type)
                REQ_FULL:    request_full(res);
                REQ_PARTIAL: request_partial(it, res);
                REQ_DONE:    busy_done(res);
                default: begin
                    if (!panel_busy()) begin
                        exited       = 1'b1;
                        res.exit_now = 1'b1;
                        shutdowns++;
                    end else begin
                        exit_pending = 1'b1;
                    end
                end
            endcase
        end
        due_results.push_back(res);
    endfunction

    task report(input string what);
        $display("mismatch on result %0d: %s", results, what);
        errors++;
    endtask

    task compare_field(input string name, input logic [FIELD_W-1:0] got_v,
                       input logic [FIELD_W-1:0] want_v);
        if (got_v !== want_v) begin
            report($sformatf("%s got %0d, expected %0d", name, got_v, want_v));
        end
    endtask

    task check_result(input result_t got);
        result_t want;
        results++;
        if (due_results.size() == 0) begin
            report("result arrived with none expected");
        end else begin
            want = due_results.pop_front();
            compare_field("finish_full", got.finish_full, want.finish_full);
            compare_field("finish_partial", got.finish_partial, want.finish_partial);
            compare_field("start_action", got.start_action, want.start_action);
            compare_field("out_left", got.out_left, want.out_left);
            compare_field("out_top", got.out_top, want.out_top);
            compare_field("out_right", got.out_right, want.out_right);
            compare_field("out_bottom", got.out_bottom, want.out_bottom);
            compare_field("exit_now", got.exit_now, want.exit_now);
        end
    endtask
endclass

module tb;
    localparam int HOLD_CYCLES = 120;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 230;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0]   cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [S_TUSER_W-1:0] s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    refresh_plan plan;
    int          tx_gap_pct   = 20;
    int          rx_stall_pct = 20;
    bit          rx_hold_req  = 1'b0;
    bit          rx_holding   = 1'b0;
    int          cycle_count  = 0;
    int          settings_used = 1;

    eink_repaint_scheduler_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("eink_repaint_scheduler_core verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.finish_full    = m_tdata[0];
            got.finish_partial = m_tdata[1];
            got.out_left       = m_tdata[13:2];
            got.out_top        = m_tdata[25:14];
            got.out_right      = m_tdata[37:26];
            got.out_bottom     = m_tdata[49:38];
            got.exit_now       = m_tdata[50];
            got.start_action   = start_t'(m_tuser);
            plan.check_result(got);
        end
    end

    // result side: random stalls plus one long hold
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_holding  = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_holding = 1'b0;
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic offer(input item_t it);
        if (!rx_holding && $urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.req_type;
        s_tdata  <= {it.rect_bottom, it.rect_right, it.rect_top, it.rect_left};
        do @(posedge aclk); while (!s_tready);
        plan.note_request(it);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (plan.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        plan.set_limit(value);
        settings_used++;
    endtask

    function automatic item_t mk(input req_type_t kind, input int l = 0, input int t = 0,
                                 input int r = 0, input int b = 0);
        item_t it;
        it.req_type    = kind;
        it.rect_left   = FIELD_W'(l);
        it.rect_top    = FIELD_W'(t);
        it.rect_right  = FIELD_W'(r);
        it.rect_bottom = FIELD_W'(b);
        return it;
    endfunction

    function automatic logic [FIELD_W-1:0] random_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return FIELD_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic item_t random_request(input int full_pct, input int partial_pct);
        item_t              it;
        int unsigned        roll;
        logic [FIELD_W-1:0] tmp;
        roll = $urandom_range(0, 99);
        if (roll < full_pct) begin
            it.req_type = REQ_FULL;
        end else if (roll < full_pct + partial_pct) begin
            it.req_type = REQ_PARTIAL;
        end else begin
            it.req_type = REQ_DONE;
        end
        it.rect_left   = random_coord();
        it.rect_top    = random_coord();
        it.rect_right  = random_coord();
        it.rect_bottom = random_coord();
        // mostly well-ordered rectangles, some left reversed
        if ($urandom_range(0, 3) != 0) begin
            if (it.rect_left > it.rect_right) begin
                tmp           = it.rect_left;
                it.rect_left  = it.rect_right;
                it.rect_right = tmp;
            end
            if (it.rect_top > it.rect_bottom) begin
                tmp            = it.rect_top;
                it.rect_top    = it.rect_bottom;
                it.rect_bottom = tmp;
            end
        end
        return it;
    endfunction

    initial begin
        logic [LIMIT_W-1:0] limits [6];
        item_t              it;
        int                 full_pct;
        plan = new();
        limits = '{4'd1, 4'd15, 4'd0, 4'd9, 4'd5, 4'd5};
        limits[4] = LIMIT_W'($urandom_range(2, 14));
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at the reset limit
        offer(mk(REQ_PARTIAL, 0, 0, 4095, 4095));
        offer(mk(REQ_PARTIAL, 10, 20, 30, 40));
        offer(mk(REQ_PARTIAL, 5, 25, 35, 38));
        offer(mk(REQ_FULL));
        offer(mk(REQ_PARTIAL, 1, 1, 2, 2));
        offer(mk(REQ_DONE));
        offer(mk(REQ_DONE));
        offer(mk(REQ_DONE));
        offer(mk(REQ_PARTIAL, 4095, 4095, 0, 0));
        offer(mk(REQ_DONE));
        repeat (4) begin
            offer(mk(REQ_PARTIAL, 100, 200, 300, 400));
            offer(mk(REQ_DONE));
        end
        offer(mk(REQ_PARTIAL, 7, 7, 7, 7));
        offer(mk(REQ_DONE));
        offer(mk(REQ_FULL));
        offer(mk(REQ_FULL));
        offer(mk(REQ_DONE));
        offer(mk(REQ_DONE));

        // random phases, one limit each
        for (int p = 0; p < 6; p++) begin
            write_limit(limits[p]);
            if (p == 5) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else begin
                tx_gap_pct   = $urandom_range(0, 40);
                rx_stall_pct = $urandom_range(0, 40);
            end
            full_pct = (limits[p] == 4'd15) ? 3 : 15;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 1 && i == 60) rx_hold_req = 1'b1;
                offer(random_request(full_pct, 50));
            end
        end

        // shutdown sequence, then requests that must be ignored
        settle();
        repeat (3) offer(mk(REQ_DONE));
        offer(mk(REQ_FULL));
        offer(mk(REQ_PARTIAL, 50, 60, 70, 80));
        offer(mk(REQ_EXIT, 4095, 4095, 4095, 4095));
        offer(mk(REQ_FULL));
        offer(mk(REQ_PARTIAL, 1, 2, 3, 4));
        offer(mk(REQ_EXIT));
        offer(mk(REQ_DONE));
        offer(mk(REQ_EXIT));
        offer(mk(REQ_PARTIAL, 0, 0, 10, 10));
        offer(mk(REQ_FULL));
        offer(mk(REQ_DONE));
        repeat (20) begin
            it = random_request(30, 40);
            it.req_type = req_type_t'($urandom_range(0, 3));
            offer(it);
        end

        settle();
        repeat (8) @(posedge aclk);
        $display("run covered %0d requests and %0d results over %0d partial_limit settings",
                 plan.requests, plan.results, settings_used);
        $display("started %0d full and %0d partial refreshes, %0d forced full, %0d merges, %0d shutdown",
                 plan.full_starts, plan.partial_starts, plan.forced_fulls, plan.merges,
                 plan.shutdowns);
        if (plan.errors == 0) begin
            $display("eink_repaint_scheduler_core verification clean");
        end else begin
            $display("eink_repaint_scheduler_core verification failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+src
src/ers_pkg.sv
src/ers_in_stage.sv
src/ers_sched.sv
src/ers_out_stage.sv
src/eink_repaint_scheduler_core.sv
verif/tb.sv
